[hdl/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer: engine
// states, item kinds, queue depth and sequencer step counts.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

  // item kinds carried in the func field
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // command queue between front and engine (power of two)
  localparam int QUEUE_DEPTH = 2;

  // last sequencer step of the start setup and of the region 2 setup
  localparam logic [2:0] START_LAST_K = 3'd4;
  localparam logic [2:0] R2_LAST_K    = 3'd7;

  // index of the fourth symmetric point
  localparam logic [1:0] LAST_IDX = 2'd3;

  // update phase counter value once all decision updates are applied
  localparam logic [1:0] PH_DONE = 2'd3;

  // engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_R2INIT,
    ST_EMIT
  } eng_state_t;

endpackage

`default_nettype wire

[hdl/mer_front.sv]
// ----------------------------------------------------------------------------
// mer_front
// Input stage: takes one transaction, squares both radii and holds the
// command until the queue has room for it.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_front #(
  parameter int CB = 12,
  parameter int RB = 11,
  parameter int QW = 1 + 2 * CB + 5 * RB
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          func,
  input  wire logic [CB-1:0] center_x,
  input  wire logic [CB-1:0] center_y,
  input  wire logic [RB-1:0] radius_x,
  input  wire logic [RB-1:0] radius_y,
  input  wire logic          q_full,
  output logic               push,
  output logic [QW-1:0]      push_data
);

  logic              f_valid;
  logic              f_func;
  logic [CB-1:0]     f_cx;
  logic [CB-1:0]     f_cy;
  logic [RB-1:0]     f_ry;
  logic [2*RB-1:0]   f_rx2;
  logic [2*RB-1:0]   f_ry2;

  // hold the command while the queue is full
  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  // capture and square the radii
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_func <= func;
      f_cx   <= center_x;
      f_cy   <= center_y;
      f_ry   <= radius_y;
      f_rx2  <= (2*RB)'(radius_x) * (2*RB)'(radius_x);
      f_ry2  <= (2*RB)'(radius_y) * (2*RB)'(radius_y);
    end
  end

  assign push_data = {f_func, f_cx, f_cy, f_ry, f_rx2, f_ry2};

endmodule

`default_nettype wire

[hdl/mer_queue.sv]
// ----------------------------------------------------------------------------
// mer_queue
// Small command queue that lets the front and the engine stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_queue #(
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [QW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output logic [QW-1:0]      head
);
  import mer_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [QW-1:0] entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/mer_engine.sv]
// ----------------------------------------------------------------------------
// mer_engine
// Back end: walks the ellipse one position per step command, sets up both
// regions on a shared multiplier and emits the symmetric points through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_engine #(
  parameter int CB = 12,
  parameter int RB = 11,
  parameter int QW = 1 + 2 * CB + 5 * RB
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire logic [QW-1:0]        head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [CB+1:0]      point_x,
  output logic signed [CB+1:0]      point_y,
  output logic                      last_of_run,
  output logic                      finished
);
  import mer_pkg::*;

  localparam int PW = CB + 2;        // point width
  localparam int SW = 3 * RB + 3;    // slope term width
  localparam int DW = 4 * RB + 4;    // decision width
  localparam int XW = RB + 1;        // walk x width
  localparam int YW = RB + 1;        // walk y width, signed
  localparam int MW = 2 * RB + 4;    // multiplier operand width
  localparam logic signed [DW-1:0] HALF_Q = 2;
  localparam logic signed [DW-1:0] QBIAS  = 3;

  // head fields
  logic            h_func;
  logic [CB-1:0]   h_cx;
  logic [CB-1:0]   h_cy;
  logic [RB-1:0]   h_ry;
  logic [2*RB-1:0] h_rx2;
  logic [2*RB-1:0] h_ry2;

  // walk state
  eng_state_t             state;
  eng_state_t             state_next;
  logic [CB-1:0]          cx;
  logic [CB-1:0]          cy;
  logic [2*RB-1:0]        rx2;
  logic [2*RB-1:0]        ry2;
  logic [RB-1:0]          ry_l;
  logic [XW-1:0]          walk_x;
  logic signed [YW-1:0]   walk_y;
  logic signed [SW-1:0]   slope_x;
  logic signed [SW-1:0]   slope_y;
  logic signed [DW-1:0]   decision;
  logic                   in_region_two;
  logic                   done_flag;

  // sequencing
  logic [2:0]             k;
  logic [1:0]             ph;
  logic [1:0]             idx;
  logic                   moved;
  logic                   upd_r2;
  logic [PW-1:0]          xp;
  logic [PW-1:0]          xm;
  logic [PW-1:0]          yp;
  logic [PW-1:0]          ym;

  // multiplier
  logic [2*MW-1:0]        prod;
  logic [MW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic                   mul_en;

  // decoded actions
  logic                   do_start;
  logic                   do_fin;
  logic                   do_plot;
  logic                   do_r2;

  // helper terms
  logic                   out_free;
  logic                   region_one_go;
  logic                   dec_neg;
  logic                   dec_pos;
  logic signed [SW-1:0]   rx2_x2;
  logic signed [SW-1:0]   ry2_x2;
  logic signed [DW-1:0]   rx2_d;
  logic signed [DW-1:0]   ry2_d;
  logic signed [DW-1:0]   ry2_x4;
  logic signed [DW-1:0]   prod_d;
  logic signed [DW-1:0]   prod_x4;
  logic [RB+1:0]          tx;
  logic signed [YW:0]     ty;
  logic [YW:0]            aty;
  logic [PW-1:0]          cxw;
  logic [PW-1:0]          cyw;
  logic [PW-1:0]          xw;
  logic [PW-1:0]          yw;
  logic [PW-1:0]          xp_c;
  logic [PW-1:0]          xm_c;
  logic [PW-1:0]          yp_c;
  logic [PW-1:0]          ym_c;

  // signed divide by four, rounding toward zero
  function automatic logic signed [DW-1:0] quarter(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] adj;
    adj = v[DW-1] ? v + QBIAS : v;
    return adj >>> 2;
  endfunction

  assign {h_func, h_cx, h_cy, h_ry, h_rx2, h_ry2} = head;

  assign out_free      = !out_valid || !out_stall;
  assign region_one_go = slope_x < slope_y;
  assign dec_neg       = decision[DW-1];
  assign dec_pos       = !decision[DW-1] && (decision != '0);

  assign rx2_x2  = $signed({{(SW-2*RB-1){1'b0}}, rx2, 1'b0});
  assign ry2_x2  = $signed({{(SW-2*RB-1){1'b0}}, ry2, 1'b0});
  assign rx2_d   = $signed(DW'(rx2));
  assign ry2_d   = $signed(DW'(ry2));
  assign ry2_x4  = $signed({{(DW-2*RB-2){1'b0}}, ry2, 2'b00});
  assign prod_d  = $signed(prod[DW-1:0]);
  assign prod_x4 = $signed({prod[DW-3:0], 2'b00});

  // region 2 setup operands: 2x+1 and |y-1|
  assign tx  = {walk_x, 1'b1};
  assign ty  = $signed({walk_y[YW-1], walk_y}) - $signed((YW+1)'(1));
  assign aty = ty[YW] ? (YW+1)'(-ty) : (YW+1)'(ty);

  // symmetric points of the current walk position, wrapped to point width
  assign cxw  = PW'(cx);
  assign cyw  = PW'(cy);
  assign xw   = PW'(walk_x);
  assign yw   = PW'(walk_y);
  assign xp_c = cxw + xw;
  assign xm_c = cxw - xw;
  assign yp_c = cyw + yw;
  assign ym_c = cyw - yw;

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_START: begin
        if (k == 3'd0) begin
          mul_en = 1'b1;
          mul_a  = MW'(rx2);
          mul_b  = MW'(ry_l);
        end
      end
      ST_R2INIT: begin
        case (k)
          3'd0: begin
            mul_en = 1'b1;
            mul_a  = MW'(tx);
            mul_b  = MW'(tx);
          end
          3'd1: begin
            mul_en = 1'b1;
            mul_a  = MW'(ry2);
            mul_b  = prod[MW-1:0];
          end
          3'd2: begin
            mul_en = 1'b1;
            mul_a  = MW'(aty);
            mul_b  = MW'(aty);
          end
          3'd3: begin
            mul_en = 1'b1;
            mul_a  = MW'(rx2);
            mul_b  = prod[MW-1:0];
          end
          3'd4: begin
            mul_en = 1'b1;
            mul_a  = MW'(rx2);
            mul_b  = MW'(ry2);
          end
          default: begin
            mul_en = 1'b0;
          end
        endcase
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and dispatch of the queue head
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_start   = 1'b0;
    do_fin     = 1'b0;
    do_plot    = 1'b0;
    do_r2      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          if (h_func == FUNC_START) begin
            do_start   = 1'b1;
            pop        = 1'b1;
            state_next = ST_START;
          end else if (out_free) begin
            if (done_flag || (in_region_two && walk_y[YW-1])) begin
              do_fin = 1'b1;
              pop    = 1'b1;
            end else if (!in_region_two && !region_one_go) begin
              do_r2      = 1'b1;
              state_next = ST_R2INIT;
            end else begin
              do_plot    = 1'b1;
              pop        = 1'b1;
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_START: begin
        if (k == START_LAST_K) begin
          state_next = ST_IDLE;
        end
      end
      ST_R2INIT: begin
        if (k == R2_LAST_K) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag     <= 1'b1;
      in_region_two <= 1'b0;
      k             <= '0;
      ph            <= PH_DONE;
      idx           <= '0;
    end else begin
      // new ellipse
      if (do_start) begin
        cx            <= h_cx;
        cy            <= h_cy;
        rx2           <= h_rx2;
        ry2           <= h_ry2;
        ry_l          <= h_ry;
        walk_x        <= '0;
        walk_y        <= $signed({1'b0, h_ry});
        slope_x       <= '0;
        in_region_two <= 1'b0;
        done_flag     <= 1'b0;
        k             <= '0;
      end

      // walk ended or nothing to draw
      if (do_fin) begin
        done_flag <= 1'b1;
      end

      if (do_r2) begin
        k <= '0;
      end

      // plot: keep the points, move the coordinates and slope terms now
      if (do_plot) begin
        xp     <= xp_c;
        xm     <= xm_c;
        yp     <= yp_c;
        ym     <= ym_c;
        idx    <= 2'd1;
        ph     <= '0;
        upd_r2 <= in_region_two;
        if (in_region_two) begin
          walk_y  <= walk_y - 1'b1;
          slope_y <= slope_y - rx2_x2;
          moved   <= !dec_pos;
          if (!dec_pos) begin
            walk_x  <= walk_x + 1'b1;
            slope_x <= slope_x + ry2_x2;
          end
        end else begin
          walk_x  <= walk_x + 1'b1;
          slope_x <= slope_x + ry2_x2;
          moved   <= !dec_neg;
          if (!dec_neg) begin
            walk_y  <= walk_y - 1'b1;
            slope_y <= slope_y - rx2_x2;
          end
        end
      end

      // decision update, one term per cycle while the points drain
      if (state == ST_EMIT) begin
        if (out_free) begin
          idx <= idx + 1'b1;
        end
        if (ph != PH_DONE) begin
          ph <= ph + 1'b1;
        end
        case (ph)
          2'd0: begin
            decision <= decision + (upd_r2 ? rx2_d : ry2_d);
          end
          2'd1: begin
            if (upd_r2) begin
              decision <= decision - DW'(slope_y);
            end else begin
              decision <= decision + DW'(slope_x);
            end
          end
          2'd2: begin
            if (moved) begin
              if (upd_r2) begin
                decision <= decision + DW'(slope_x);
              end else begin
                decision <= decision - DW'(slope_y);
              end
            end
          end
          default: begin
            decision <= decision;
          end
        endcase
      end

      // region 1 setup
      if (state == ST_START) begin
        k <= k + 1'b1;
        case (k)
          3'd1: begin
            slope_y  <= $signed({prod[SW-2:0], 1'b0});
            decision <= ry2_x4 + rx2_d;
          end
          3'd2: begin
            decision <= decision - prod_x4;
          end
          3'd3: begin
            decision <= decision + HALF_Q;
          end
          3'd4: begin
            decision <= quarter(decision);
          end
          default: begin
            decision <= decision;
          end
        endcase
      end

      // region 2 setup
      if (state == ST_R2INIT) begin
        k <= k + 1'b1;
        case (k)
          3'd2: begin
            decision <= prod_d;
          end
          3'd4: begin
            decision <= decision + prod_x4;
          end
          3'd5: begin
            decision <= decision - prod_x4;
          end
          3'd6: begin
            decision <= decision + HALF_Q;
          end
          3'd7: begin
            decision      <= quarter(decision);
            in_region_two <= 1'b1;
          end
          default: begin
            decision <= decision;
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_plot) begin
      out_valid <= 1'b1;
    end else if (do_fin) begin
      out_valid <= 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_plot) begin
      point_x     <= xp_c;
      point_y     <= yp_c;
      last_of_run <= 1'b0;
      finished    <= 1'b0;
    end else if (do_fin) begin
      point_x     <= '0;
      point_y     <= '0;
      last_of_run <= 1'b1;
      finished    <= 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      point_x     <= idx[0] ? xm : xp;
      point_y     <= idx[1] ? ym : yp;
      last_of_run <= (idx == LAST_IDX);
      finished    <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse walker producing four-way symmetric pixel positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one transaction per command:
//   func = 0 starts an ellipse from center and radii and gives no result,
//   func = 1 advances the walk by one position.
//   Output channel (out_valid / out_stall) gives the results: four points per
//   plotting step, last_of_run set on the fourth, or one finished transaction
//   once the walk is over (also for a step before any start).
// Flow:
//   The first point of a step passes the input register, the command queue
//   and the output register. A plotting step sends one point per cycle
//   through the output register while out_stall is low; a start makes one
//   multiply on the shared multiplier plus the quarter-unit setup, and the
//   one step that crosses into region 2 adds setup on the same multiplier.
//   A two-entry command queue behind the input register keeps the input open
//   while the engine is busy.
// Reset and stall:
//   Synchronous reset empties the queue and output register and leaves the
//   block with nothing to draw. While out_stall is high the pending point
//   holds and point output waits; the input stalls only once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      func,
  input  wire logic [COORD_BITS-1:0]     center_x,
  input  wire logic [COORD_BITS-1:0]     center_y,
  input  wire logic [RADIUS_BITS-1:0]    radius_x,
  input  wire logic [RADIUS_BITS-1:0]    radius_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_BITS+1:0]   point_x,
  output logic signed [COORD_BITS+1:0]   point_y,
  output logic                           last_of_run,
  output logic                           finished
);

  localparam int QW = 1 + 2 * COORD_BITS + 5 * RADIUS_BITS;

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  logic [QW-1:0] push_data;
  logic [QW-1:0] head;

  // front: capture and square
  mer_front #(
    .CB (COORD_BITS),
    .RB (RADIUS_BITS),
    .QW (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // command queue
  mer_queue #(
    .QW (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  // back: walk and emit
  mer_engine #(
    .CB (COORD_BITS),
    .RB (RADIUS_BITS),
    .QW (QW)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_of_run (last_of_run),
    .finished    (finished)
  );

endmodule

`default_nettype wire
